// ===== rtl/gpm_pkg.sv =====
`default_nettype none

package gpm_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        TOK_LIT = 2'd0,
        TOK_ONE = 2'd1,
        TOK_RUN = 2'd2
    } tok_kind_t;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    localparam logic [7:0] SYM_BACKSLASH = 8'h5C;
    localparam logic [7:0] SYM_QUESTION  = 8'h3F;
    localparam logic [7:0] SYM_ASTERISK  = 8'h2A;

    // token broadcast to the cell row on a pattern append
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] sym;
    } tok_t;

    // what one cell hands on for the current text byte
    typedef struct packed {
        logic run;   // star position, feeds the closure carry chain
        logic stay;  // star keeps its own position active
        logic fwd;   // position after this one becomes active
    } cell_out_t;

endpackage

`default_nettype wire

// ===== rtl/gpm_req_if.sv =====
`default_nettype none

interface gpm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink (input valid, input action, input symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/gpm_resp_if.sv =====
`default_nettype none

interface gpm_resp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, output status, input ready);
    modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/glob_pattern_match_unit.sv =====
`default_nettype none

// Whole-text glob matcher ('*', '?', backslash escape). Clear and append
// requests build the pattern into a row of MAX_TOKENS cells, one token per
// cell; text requests then move a set of active positions through the row,
// and an end-of-text request returns match, no match or overflow. Every
// request is acted on when accepted, so requests may follow back to back. The star
// closure is a single carry-chain add across MAX_TOKENS+1 positions ahead of
// the cell row, which sets the clock period. The status appears on the
// response channel the cycle after the end-of-text request and is held there
// until taken; meanwhile other requests are still accepted, and only a
// further end-of-text request waits.
module glob_pattern_match_unit
    import gpm_pkg::*;
#(
    parameter int MAX_TOKENS = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_write_en,
    input  wire logic  cfg_write_data,
    gpm_req_if.sink    req,
    gpm_resp_if.source resp
);

    localparam int POS_W = MAX_TOKENS + 1;
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    logic             no_escape_reg;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             esc_reg,       esc_next;
    logic             overflow_reg,  overflow_next;
    logic [POS_W-1:0] active_reg,    active_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg,    status_next;

    logic             fire;
    logic             full;
    logic             tok_add;
    tok_t             tok;
    logic [POS_W-1:0] run_vec;
    logic [POS_W-1:0] gen_vec;
    logic [POS_W-1:0] sum;
    logic [POS_W-1:0] carries;
    logic [POS_W-1:0] closed;
    logic [POS_W-1:0] stepped;
    cell_out_t        co [MAX_TOKENS];

    assign req.ready   = !(out_valid_reg && !resp.ready && (req.action == ACT_END));
    assign fire        = req.valid && req.ready;
    assign full        = (count_reg == CNT_W'(MAX_TOKENS));
    assign resp.valid  = out_valid_reg;
    assign resp.status = status_reg;

    // pattern byte decode
    always_comb
    begin
        tok_add  = 1'b1;
        tok.kind = TOK_LIT;
        tok.sym  = req.symbol;
        if (esc_reg)
        begin
            tok.kind = TOK_LIT;
        end
        else if (!no_escape_reg && (req.symbol == SYM_BACKSLASH))
        begin
            tok_add = 1'b0;
        end
        else if (req.symbol == SYM_ASTERISK)
        begin
            tok.kind = TOK_RUN;
            tok.sym  = 8'd0;
        end
        else if (req.symbol == SYM_QUESTION)
        begin
            tok.kind = TOK_ONE;
            tok.sym  = 8'd0;
        end
    end

    generate
        for (genvar i = 0; i < MAX_TOKENS; i++)
        begin : g_cell
            gpm_cell u_cell (
                .clk      (clk),
                .wr_en    (fire && (req.action == ACT_APPEND) && tok_add && !full
                           && (count_reg == CNT_W'(i))),
                .wr_tok   (tok),
                .en       (count_reg > CNT_W'(i)),
                .cur      (closed[i]),
                .text_sym (req.symbol),
                .co       (co[i])
            );
            assign run_vec[i] = co[i].run;
        end
    endgenerate

    assign run_vec[MAX_TOKENS] = 1'b0;

    // Closure: position j+1 joins when j is closed and j is a star. This is
    // carry propagation with generate = active & star, propagate = star.
    // The top position is never a star, so nothing carries out of the add.
    assign gen_vec = active_reg & run_vec;
    assign sum     = gen_vec + run_vec;
    assign carries = sum ^ gen_vec ^ run_vec;
    assign closed  = active_reg | carries;

    always_comb
    begin
        stepped = '0;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            stepped[i]   = stepped[i] | co[i].stay;
            stepped[i+1] = co[i].fwd;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        esc_next      = esc_reg;
        overflow_next = overflow_reg;
        active_next   = active_reg;
        if (fire)
        begin
            case (action_t'(req.action))
                ACT_CLEAR:
                begin
                    count_next    = '0;
                    esc_next      = 1'b0;
                    overflow_next = 1'b0;
                    active_next   = POS_W'(1);
                end
                ACT_APPEND:
                begin
                    active_next = POS_W'(1);
                    esc_next    = !esc_reg && !no_escape_reg
                                  && (req.symbol == SYM_BACKSLASH);
                    if (tok_add)
                    begin
                        if (full)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                ACT_TEXT:
                begin
                    active_next = stepped;
                end
                ACT_END:
                begin
                    active_next = POS_W'(1);
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !resp.ready;
        status_next    = status_reg;
        if (fire && (req.action == ACT_END))
        begin
            out_valid_next = 1'b1;
            if (overflow_reg)
            begin
                status_next = ST_OVERFLOW;
            end
            else if (closed[count_reg])
            begin
                status_next = ST_MATCH;
            end
            else
            begin
                status_next = ST_NO_MATCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_escape_reg <= 1'b0;
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            overflow_reg  <= 1'b0;
            active_reg    <= POS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                no_escape_reg <= cfg_write_data;
            end
            count_reg     <= count_next;
            esc_reg       <= esc_next;
            overflow_reg  <= overflow_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    a_end_gives_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (req.action == ACT_END)) |=> resp.valid)
        else $error("end-of-text request produced no response");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (count_reg == CNT_W'(MAX_TOKENS)))
        else $error("overflow flagged with room left in the cell row");

    a_active_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & ~((POS_W'(2) << count_reg) - POS_W'(1))) == '0)
        else $error("active position beyond the pattern end");

    a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && !resp.ready) |=> (resp.valid && $stable(resp.status)))
        else $error("stalled response changed");

endmodule

`default_nettype wire

// ===== rtl/gpm_cell.sv =====
`default_nettype none

module gpm_cell
    import gpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       wr_en,
    input  wire tok_t       wr_tok,
    input  wire logic       en,
    input  wire logic       cur,
    input  wire logic [7:0] text_sym,
    output cell_out_t       co
);

    tok_t tok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tok_reg <= wr_tok;
        end
    end

    always_comb
    begin
        co.run  = en && (tok_reg.kind == TOK_RUN);
        co.stay = cur && co.run;
        co.fwd  = 1'b0;
        if (en && cur)
        begin
            case (tok_reg.kind)
                TOK_LIT: co.fwd = (tok_reg.sym == text_sym);
                TOK_ONE: co.fwd = 1'b1;
                default: co.fwd = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sim/glob_pattern_match_unit_test.sv =====
`timescale 1ns / 1ps

module glob_pattern_match_unit_test
    import gpm_pkg::*;
();

    localparam int MAX_TOKENS = 32;
    localparam int ITEM_TARGET = 1700;

    // Mirrors the matcher: token row, escape and overflow flags, active set.
    class glob_scoreboard;
        tok_t                tokens[MAX_TOKENS];
        int unsigned         tok_count;
        bit                  esc_pending;
        bit                  overflowed;
        bit                  no_escape;
        logic [MAX_TOKENS:0] active;
        status_t             expected_status[$];
        int unsigned         errors;

        function new();
            tok_count   = 0;
            esc_pending = 1'b0;
            overflowed  = 1'b0;
            no_escape   = 1'b0;
            active      = 1;
            errors      = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        function void set_no_escape(bit v);
            no_escape = v;
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        function void push_token(tok_kind_t k, logic [7:0] s);
            if (tok_count < MAX_TOKENS) begin
                tokens[tok_count].kind = k;
                tokens[tok_count].sym  = s;
                tok_count++;
            end
            else
                overflowed = 1'b1;
        endfunction

        // ascending walk lets consecutive stars chain through
        function logic [MAX_TOKENS:0] star_closure(logic [MAX_TOKENS:0] set);
            for (int i = 0; i < tok_count; i++)
                if (set[i] && tokens[i].kind == TOK_RUN)
                    set[i + 1] = 1'b1;
            return set;
        endfunction

        function void note_request(action_t act, logic [7:0] s);
            logic [MAX_TOKENS:0] cur;
            logic [MAX_TOKENS:0] nxt;
            case (act)
                ACT_CLEAR:
                begin
                    tok_count   = 0;
                    esc_pending = 1'b0;
                    overflowed  = 1'b0;
                    active      = 1;
                end
                ACT_APPEND:
                begin
                    active = 1;
                    if (esc_pending)
                    begin
                        esc_pending = 1'b0;
                        push_token(TOK_LIT, s);
                    end
                    else if (!no_escape && s == SYM_BACKSLASH)
                        esc_pending = 1'b1;
                    else if (s == SYM_ASTERISK)
                        push_token(TOK_RUN, 8'h00);
                    else if (s == SYM_QUESTION)
                        push_token(TOK_ONE, 8'h00);
                    else
                        push_token(TOK_LIT, s);
                end
                ACT_TEXT:
                begin
                    cur = star_closure(active);
                    nxt = '0;
                    for (int i = 0; i < tok_count; i++)
                    begin
                        if (cur[i])
                        begin
                            if (tokens[i].kind == TOK_RUN)
                                nxt[i] = 1'b1;
                            else if (tokens[i].kind == TOK_ONE || tokens[i].sym == s)
                                nxt[i + 1] = 1'b1;
                        end
                    end
                    active = nxt;
                end
                default:
                begin
                    cur = star_closure(active);
                    if (overflowed)
                        expected_status.push_back(ST_OVERFLOW);
                    else if (cur[tok_count])
                        expected_status.push_back(ST_MATCH);
                    else
                        expected_status.push_back(ST_NO_MATCH);
                    active = 1;
                end
            endcase
        endfunction

        task check_status(logic [1:0] got);
            status_t want;
            if (expected_status.size() == 0)
                report($sformatf("status %0d with no end-of-text request outstanding", got));
            else
            begin
                want = expected_status.pop_front();
                if (got !== want)
                    report($sformatf("status %0d, expected %s", got, want.name()));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    gpm_req_if  req_ch ();
    gpm_resp_if resp_ch ();

    glob_pattern_match_unit #(
        .MAX_TOKENS(MAX_TOKENS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .resp           (resp_ch)
    );

    glob_scoreboard sb;
    int unsigned    items_sent;
    bit             no_idle;
    bit             cur_no_escape;
    logic [7:0]     pat_q[$];
    logic [7:0]     txt_q[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("glob_pattern_match_unit verification failed");
        $finish;
    end

    function automatic int unsigned draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(action_t act, logic [7:0] s);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.action = act;
        req_ch.symbol = s;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(act, s);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        // appends and text bytes leave no response to wait for
        repeat (4) @(negedge clk);
    endtask

    task automatic write_no_escape(bit v);
        wait_until_idle();
        cfg_write_en   = 1'b1;
        cfg_write_data = v;
        @(negedge clk);
        cfg_write_en   = 1'b0;
        sb.set_no_escape(v);
        cur_no_escape = v;
    endtask

    function automatic logic [7:0] pick_pattern_byte();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r <= 5)
            return SYM_ASTERISK;
        if (r <= 8)
            return SYM_QUESTION;
        if (r <= 10)
            return SYM_BACKSLASH;
        if (r <= 17)
            return 8'h61 + 8'($urandom_range(0, 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r <= 6)
            return 8'h61 + 8'($urandom_range(0, 1));
        if (r == 7)
            return SYM_ASTERISK;
        if (r == 8)
            return SYM_BACKSLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    // text that the pattern in pat_q should accept
    task automatic make_matching_text();
        bit esc;
        esc = 1'b0;
        txt_q.delete();
        foreach (pat_q[i])
        begin
            if (esc)
            begin
                txt_q.push_back(pat_q[i]);
                esc = 1'b0;
            end
            else if (!cur_no_escape && pat_q[i] == SYM_BACKSLASH)
                esc = 1'b1;
            else if (pat_q[i] == SYM_ASTERISK)
                repeat ($urandom_range(0, 3)) txt_q.push_back(pick_text_byte());
            else if (pat_q[i] == SYM_QUESTION)
                txt_q.push_back(8'($urandom_range(0, 255)));
            else
                txt_q.push_back(pat_q[i]);
        end
    endtask

    task automatic run_sequence();
        int unsigned pat_len;
        int unsigned txt_len;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_request(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 4) != 0)
            send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
        pat_len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
        pat_q.delete();
        repeat (pat_len) pat_q.push_back(pick_pattern_byte());
        foreach (pat_q[i])
            send_request(ACT_APPEND, pat_q[i]);
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                make_matching_text();
                if (txt_q.size() != 0 && $urandom_range(0, 4) == 0)
                    txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else
            begin
                txt_q.delete();
                txt_len = $urandom_range(0, 8);
                repeat (txt_len) txt_q.push_back(pick_text_byte());
            end
            foreach (txt_q[i])
                send_request(ACT_TEXT, txt_q[i]);
            // now and then the text is abandoned without an end marker
            if ($urandom_range(0, 9) != 0)
                send_request(ACT_END, 8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
            sb.check_status(resp_ch.status);
    end

    // response side: stall is applied once the status is offered
    initial
    begin
        int unsigned gap;
        resp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                resp_ch.ready = 1'b0;
                do
                    @(posedge clk);
                while (resp_ch.valid !== 1'b1);
                repeat (gap) @(negedge clk);
            end
            resp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (resp_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        sb             = new();
        items_sent     = 0;
        no_idle        = 1'b0;
        cur_no_escape  = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_CLEAR;
        req_ch.symbol  = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_no_escape(1'b0);
        // empty pattern: empty text matches, any byte does not
        send_request(ACT_END, 8'h00);
        send_request(ACT_TEXT, 8'h00);
        send_request(ACT_END, 8'hFF);
        // '?' takes byte zero
        send_request(ACT_APPEND, SYM_QUESTION);
        send_request(ACT_TEXT, 8'h00);
        send_request(ACT_END, 8'h00);
        send_request(ACT_APPEND, SYM_ASTERISK);
        send_request(ACT_TEXT, 8'hFF);
        send_request(ACT_END, 8'h00);
        // trailing lone backslash is dropped
        send_request(ACT_CLEAR, 8'hFF);
        send_request(ACT_APPEND, SYM_BACKSLASH);
        send_request(ACT_END, 8'h00);
        // escaped star is a literal
        send_request(ACT_APPEND, SYM_ASTERISK);
        send_request(ACT_TEXT, SYM_ASTERISK);
        send_request(ACT_END, 8'h00);
        send_request(ACT_APPEND, SYM_BACKSLASH);
        send_request(ACT_APPEND, SYM_BACKSLASH);
        send_request(ACT_TEXT, SYM_ASTERISK);
        send_request(ACT_TEXT, SYM_BACKSLASH);
        send_request(ACT_END, 8'h00);

        write_no_escape(1'b1);
        send_request(ACT_CLEAR, 8'h00);
        send_request(ACT_APPEND, SYM_BACKSLASH);
        send_request(ACT_TEXT, SYM_BACKSLASH);
        send_request(ACT_END, 8'h00);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < 2)
                write_no_escape(phase[0]);
            else
                write_no_escape(1'($urandom_range(0, 1)));
            no_idle     = (phase % 4 == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < 150 && items_sent < ITEM_TARGET)
                run_sequence();
            phase++;
        end

        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("glob_pattern_match_unit verification clean");
        else
            $display("glob_pattern_match_unit verification failed");
        $finish;
    end

endmodule
